/* rtl/tsgt_pkg.sv */
// Shared types and constants for the touch swipe gesture tracker.
// No dependencies; used by tsgt_tracker and the top level.
package tsgt_pkg;

   localparam int XWidth     = 9;
   localparam int YWidth     = 8;
   localparam int ThrWidth   = 9;
   localparam int RunSlots   = 4;
   localparam int SlotWidth  = $clog2(RunSlots);
   localparam int CountWidth = $clog2(RunSlots + 1);

   localparam logic [ThrWidth-1:0] SwipeThresholdReset = 9'd50;

   typedef enum logic [1:0] {
      KIND_BEGAN = 2'd0,
      KIND_MOVED = 2'd1,
      KIND_ENDED = 2'd2,
      KIND_SWIPE = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      DIR_RIGHT      = 3'd0,
      DIR_LEFT       = 3'd1,
      DIR_UP         = 3'd2,
      DIR_DOWN       = 3'd3,
      DIR_LEFT_UP    = 3'd4,
      DIR_RIGHT_UP   = 3'd5,
      DIR_LEFT_DOWN  = 3'd6,
      DIR_RIGHT_DOWN = 3'd7
   } swipe_dir_type;

   typedef struct packed {
      event_kind_type    event_kind;
      logic [XWidth-1:0] point_x;
      logic [YWidth-1:0] point_y;
      swipe_dir_type     swipe_direction;
   } result_type;

   // results caused by one poll, packed from slot 0 up
   typedef struct packed {
      logic [CountWidth-1:0]       count;
      result_type [RunSlots-1:0]   slot;
   } run_type;

endpackage

/* rtl/touch_swipe_gesture_tracker_unit.sv */
// Top level of the touch swipe gesture tracker: stream ports, threshold
// register and result run buffer. Depends on tsgt_pkg and tsgt_tracker.
//
// Each poll's results (none, one, or on a release up to four: ended plus
// swipes) land in a four-entry run buffer, which drains one beat per cycle
// while rsp_tready is high, with tlast on the final beat of the run. A new
// poll is taken as soon as the buffer is empty or its last beat leaves in the
// same cycle, so polls causing at most one result flow at one per cycle while
// rsp_tready stays high, and a release yielding n results takes n beats.
// The swipe threshold resets to 50.
module touch_swipe_gesture_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // touch_down[0], touch_x[9:1], touch_y[17:10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // point_x[8:0], point_y[16:9], swipe_direction[19:17]
   output logic [1:0]  rsp_tuser,   // event_kind[1:0]
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_wr_en,
   input  logic [tsgt_pkg::ThrWidth-1:0] csr_wr_data   // swipe_threshold
);
   import tsgt_pkg::*;

   logic [ThrWidth-1:0]   threshold_ff;
   run_type               run_new;
   result_type [RunSlots-1:0] slot_ff;
   logic [CountWidth-1:0] left_ff;
   logic [SlotWidth-1:0]  ptr_ff;
   logic                  req_beat, rsp_beat;
   result_type            cur;

   assign rsp_tvalid = (left_ff != '0);
   assign rsp_beat   = rsp_tvalid & rsp_tready;
   assign req_tready = (left_ff == '0) || ((left_ff == CountWidth'(1)) && rsp_tready);
   assign req_beat   = req_tvalid & req_tready;

   tsgt_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_beat),
      .touch_down      (req_tdata[0]),
      .touch_x         (req_tdata[9:1]),
      .touch_y         (req_tdata[17:10]),
      .swipe_threshold (threshold_ff),
      .run             (run_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= SwipeThresholdReset;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ptr_ff  <= '0;
      end else if (req_beat) begin
         left_ff <= run_new.count;
         ptr_ff  <= '0;
      end else if (rsp_beat) begin
         left_ff <= left_ff - CountWidth'(1);
         ptr_ff  <= ptr_ff + SlotWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         slot_ff <= run_new.slot;
      end
   end

   assign cur       = slot_ff[ptr_ff];
   assign rsp_tuser = cur.event_kind;
   assign rsp_tdata = {4'b0000, cur.swipe_direction, cur.point_y, cur.point_x};
   assign rsp_tlast = (left_ff == CountWidth'(1));

endmodule

/* rtl/tsgt_tracker.sv */
// Touch state tracker: holds touching flag, first and last point, and
// builds the run of results for the poll on its inputs. Uses tsgt_pkg.
module tsgt_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           touch_down,
   input  logic [tsgt_pkg::XWidth-1:0]    touch_x,
   input  logic [tsgt_pkg::YWidth-1:0]    touch_y,
   input  logic [tsgt_pkg::ThrWidth-1:0]  swipe_threshold,
   output tsgt_pkg::run_type              run
);
   import tsgt_pkg::*;

   logic              touching_ff, touching_in;
   logic [XWidth-1:0] first_x_ff, first_x_in, last_x_ff, last_x_in;
   logic [YWidth-1:0] first_y_ff, first_y_in, last_y_ff, last_y_in;

   // offsets and threshold in 11-bit signed
   logic signed [10:0] h_off, v_off, thr;
   logic               go_right, go_left, go_up, go_down, hz, vt;
   swipe_dir_type      h_dir, v_dir, d_dir;
   logic               new_point;

   assign h_off = $signed({2'b00, first_x_ff}) - $signed({2'b00, last_x_ff});
   assign v_off = $signed({3'b000, first_y_ff}) - $signed({3'b000, last_y_ff});
   assign thr   = $signed({2'b00, swipe_threshold});

   assign go_right = h_off > thr;
   assign go_left  = h_off < -thr;
   assign go_up    = v_off < -thr;
   assign go_down  = v_off > thr;
   assign hz       = go_right | go_left;
   assign vt       = go_up | go_down;

   assign new_point = (touch_x != last_x_ff) || (touch_y != last_y_ff) || !touching_ff;

   always_comb begin
      h_dir = go_right ? DIR_RIGHT : DIR_LEFT;
      v_dir = go_up ? DIR_UP : DIR_DOWN;
      if (go_up) begin
         d_dir = go_left ? DIR_LEFT_UP : DIR_RIGHT_UP;
      end else begin
         d_dir = go_left ? DIR_LEFT_DOWN : DIR_RIGHT_DOWN;
      end
   end

   always_comb begin
      touching_in = touching_ff;
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      run         = '0;
      if (touch_down) begin
         if (new_point) begin
            run.count = CountWidth'(1);
            run.slot[0].event_kind = touching_ff ? KIND_MOVED : KIND_BEGAN;
            run.slot[0].point_x    = touch_x;
            run.slot[0].point_y    = touch_y;
            if (!touching_ff) begin
               first_x_in = touch_x;
               first_y_in = touch_y;
            end
            last_x_in   = touch_x;
            last_y_in   = touch_y;
            touching_in = 1'b1;
         end
      end else if (touching_ff) begin
         touching_in = 1'b0;
         run.count = CountWidth'(1) + CountWidth'(hz) + CountWidth'(vt)
                   + CountWidth'(hz & vt);
         run.slot[0].event_kind = KIND_ENDED;
         run.slot[0].point_x    = last_x_ff;
         run.slot[0].point_y    = last_y_ff;
         // horizontal, then vertical, then diagonal; diagonal only with both
         run.slot[1].event_kind      = KIND_SWIPE;
         run.slot[1].swipe_direction = hz ? h_dir : v_dir;
         run.slot[2].event_kind      = KIND_SWIPE;
         run.slot[2].swipe_direction = v_dir;
         run.slot[3].event_kind      = KIND_SWIPE;
         run.slot[3].swipe_direction = d_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touching_ff <= 1'b0;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
      end else if (accept) begin
         touching_ff <= touching_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
      end
   end

endmodule

/* dv/tb.sv */
// Self-checking bench for touch_swipe_gesture_tracker_unit: touch polls in,
// event beats checked against an in-bench tracker of touch state and swipes.
// Depends on tsgt_pkg and the RTL of the unit.
module tb;
   import tsgt_pkg::*;

   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 8;
   localparam int MaxX          = 319;
   localparam int MaxY          = 239;
   localparam int FullX         = (1 << XWidth) - 1;
   localparam int FullY         = (1 << YWidth) - 1;
   localparam int PhaseItems    = 42;

   typedef struct {
      result_type fields;
      logic       last;
   } event_beat_type;

   // Tracks touch state and the threshold, and holds the event beats still owed.
   class gesture_ledger;
      logic [ThrWidth-1:0] threshold;
      logic                touching;
      logic [XWidth-1:0]   first_x, last_x;
      logic [YWidth-1:0]   first_y, last_y;
      event_beat_type      pending_events[$];
      int                  mismatch_count;

      function new();
         threshold      = SwipeThresholdReset;
         touching       = 1'b0;
         first_x        = '0;
         first_y        = '0;
         last_x         = '0;
         last_y         = '0;
         mismatch_count = 0;
      endfunction

      function void push_event(event_kind_type kind, logic [XWidth-1:0] px,
                               logic [YWidth-1:0] py, swipe_dir_type dir);
         event_beat_type beat;
         beat.fields.event_kind      = kind;
         beat.fields.point_x         = px;
         beat.fields.point_y         = py;
         beat.fields.swipe_direction = dir;
         beat.last                   = 1'b0;
         pending_events.push_back(beat);
      endfunction

      function void take_poll(logic down, logic [XWidth-1:0] x, logic [YWidth-1:0] y);
         int   base, thr, h, v;
         logic right, left, up, dn;
         base = pending_events.size();
         if (down) begin
            // a press at the same point while touching is silent
            if (!touching || x != last_x || y != last_y) begin
               // non-swipe beats carry direction code zero
               push_event(touching ? KIND_MOVED : KIND_BEGAN, x, y, DIR_RIGHT);
               if (!touching) begin
                  first_x = x;
                  first_y = y;
               end
               last_x   = x;
               last_y   = y;
               touching = 1'b1;
            end
         end else if (touching) begin
            thr   = int'(threshold);
            h     = int'(first_x) - int'(last_x);
            v     = int'(first_y) - int'(last_y);
            right = h > thr;
            left  = h < -thr;
            up    = v < -thr;
            dn    = v > thr;
            touching = 1'b0;
            push_event(KIND_ENDED, last_x, last_y, DIR_RIGHT);
            if (right)       push_event(KIND_SWIPE, '0, '0, DIR_RIGHT);
            if (left)        push_event(KIND_SWIPE, '0, '0, DIR_LEFT);
            if (up)          push_event(KIND_SWIPE, '0, '0, DIR_UP);
            if (dn)          push_event(KIND_SWIPE, '0, '0, DIR_DOWN);
            if (left && up)  push_event(KIND_SWIPE, '0, '0, DIR_LEFT_UP);
            if (right && up) push_event(KIND_SWIPE, '0, '0, DIR_RIGHT_UP);
            if (left && dn)  push_event(KIND_SWIPE, '0, '0, DIR_LEFT_DOWN);
            if (right && dn) push_event(KIND_SWIPE, '0, '0, DIR_RIGHT_DOWN);
         end
         if (pending_events.size() > base)
            pending_events[pending_events.size() - 1].last = 1'b1;
      endfunction

      function void match_event(logic [1:0] kind, logic [XWidth-1:0] px,
                                logic [YWidth-1:0] py, logic [2:0] dir, logic last);
         event_beat_type want;
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: kind %0d x %0d y %0d dir %0d last %0b",
                        kind, px, py, dir, last);
            return;
         end
         want = pending_events.pop_front();
         if (want.fields.event_kind !== kind || want.fields.point_x !== px ||
             want.fields.point_y !== py || want.fields.swipe_direction !== dir ||
             want.last !== last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("beat mismatch: expected kind %0d x %0d y %0d dir %0d last %0b,",
                        want.fields.event_kind, want.fields.point_x,
                        want.fields.point_y, want.fields.swipe_direction, want.last,
                        " got kind %0d x %0d y %0d dir %0d last %0b",
                        kind, px, py, dir, last);
         end
      endfunction

      function int outstanding();
         return pending_events.size();
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [23:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wr_en   = 1'b0;
   logic [ThrWidth-1:0] csr_wr_data = '0;

   gesture_ledger ledger;
   logic          traffic_gaps = 1'b1;
   int            polls_sent   = 0;
   int            stall_left   = 0;
   int            quiet_cycles = 0;

   touch_swipe_gesture_tracker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // event sink: check each beat, then pick next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            ledger.match_event(rsp_tuser, rsp_tdata[8:0], rsp_tdata[16:9],
                               rsp_tdata[19:17], rsp_tlast);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= int'($urandom_range(0, 2));
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("FAIL touch_swipe_gesture_tracker_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_poll(input logic down, input logic [XWidth-1:0] x,
                            input logic [YWidth-1:0] y);
      if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, y, x, down};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.take_poll(down, x, y);
      polls_sent++;
   endtask

   // only touched once the block has drained
   task automatic set_threshold(input logic [ThrWidth-1:0] value);
      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.threshold = value;
   endtask

   function automatic logic [XWidth-1:0] pick_x();
      if ($urandom_range(0, 7) == 0) return XWidth'($urandom_range(0, FullX));
      return XWidth'($urandom_range(0, MaxX));
   endfunction

   function automatic logic [YWidth-1:0] pick_y();
      if ($urandom_range(0, 7) == 0) return YWidth'($urandom_range(0, FullY));
      return YWidth'($urandom_range(0, MaxY));
   endfunction

   // end point a couple of pixels either side of the swipe threshold
   function automatic int swipe_end(int origin, int full);
      int offset, pos;
      offset = int'(ledger.threshold) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) offset = -offset;
      pos = origin - offset;
      if (pos < 0 || pos > full) pos = int'($urandom_range(0, full));
      return pos;
   endfunction

   task automatic run_gesture();
      logic [XWidth-1:0] x0, cx;
      logic [YWidth-1:0] y0, cy;
      int                moves;
      x0 = pick_x();
      y0 = pick_y();
      cx = x0;
      cy = y0;
      send_poll(1'b1, x0, y0);
      moves = int'($urandom_range(0, 4));
      for (int i = 0; i < moves; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            cx = pick_x();
            cy = pick_y();
         end
         send_poll(1'b1, cx, cy);
      end
      if ($urandom_range(0, 1)) begin
         cx = ($urandom_range(0, 3) != 0) ? XWidth'(swipe_end(int'(x0), FullX)) : x0;
         cy = ($urandom_range(0, 3) != 0) ? YWidth'(swipe_end(int'(y0), FullY)) : y0;
         send_poll(1'b1, cx, cy);
      end
      // sometimes the release goes missing and the next press continues the touch
      if ($urandom_range(0, 7) != 0)
         send_poll(1'b0, XWidth'($urandom_range(0, FullX)),
                   YWidth'($urandom_range(0, FullY)));
   endtask

   task automatic run_phase(input int count);
      int stop_at;
      stop_at = polls_sent + count;
      while (polls_sent < stop_at) begin
         case ($urandom_range(0, 7))
            0: send_poll(1'b0, XWidth'($urandom_range(0, FullX)),
                         YWidth'($urandom_range(0, FullY)));
            1: send_poll(1'b1, pick_x(), pick_y());
            default: run_gesture();
         endcase
      end
   endtask

   initial begin
      ledger = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle release, repeats, extremes, every direction, threshold edges
      send_poll(1'b0, 9'd511, 8'd255);
      send_poll(1'b1, 9'd0, 8'd0);
      send_poll(1'b1, 9'd0, 8'd0);
      send_poll(1'b1, 9'd319, 8'd239);
      send_poll(1'b1, 9'd511, 8'd255);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd300, 8'd10);
      send_poll(1'b1, 9'd100, 8'd200);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd10, 8'd200);
      send_poll(1'b1, 9'd200, 8'd10);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd200, 8'd200);
      send_poll(1'b1, 9'd10, 8'd10);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd100, 8'd100);
      send_poll(1'b1, 9'd150, 8'd150);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd100, 8'd100);
      send_poll(1'b1, 9'd49, 8'd151);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b1, 9'd151, 8'd49);
      send_poll(1'b0, 9'd0, 8'd0);
      send_poll(1'b0, 9'd0, 8'd0);

      set_threshold(9'd0);
      run_phase(PhaseItems);
      set_threshold(9'd511);
      run_phase(PhaseItems);
      set_threshold(ThrWidth'($urandom_range(2, 120)));
      run_phase(PhaseItems);
      set_threshold(9'd1);
      run_phase(PhaseItems);
      set_threshold(ThrWidth'($urandom_range(121, 510)));
      run_phase(PhaseItems);
      set_threshold(SwipeThresholdReset);
      traffic_gaps = 1'b0;
      run_phase(PhaseItems);

      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.outstanding() == 0)
         $display("PASS touch_swipe_gesture_tracker_unit");
      else
         $display("FAIL touch_swipe_gesture_tracker_unit");
      $finish;
   end

endmodule
